FILE: rtl/core/reso_pkg.sv
`default_nettype none

package reso_pkg;

    localparam int RING_SLOTS_DEF = 16;

    localparam int HANDLE_W   = 32;
    localparam int SIZE_W     = 16;
    localparam int OFFSET_W   = 20;
    localparam int SLOT_OUT_W = 4;

    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 88;

    localparam logic MODE_ADD  = 1'b0;
    localparam logic MODE_FIND = 1'b1;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [SIZE_W-1:0]   size;
    } t_entry;

    // Lookup token walking the chain, oldest entry first.
    typedef struct packed {
        logic                  valid;
        logic                  found;
        logic [OFFSET_W-1:0]   rem;
        logic [HANDLE_W-1:0]   handle;
        logic [SLOT_OUT_W-1:0] slot;
    } t_tok;

    typedef enum logic {
        ST_IDLE,
        ST_WALK
    } t_state;

endpackage

`default_nettype wire

FILE: rtl/core/ring_entry_store_offset_lookup_core.sv
`default_nettype none

// Ring of RING_SLOTS entries (handle, byte size) kept in a row of cells in
// age order, cell 0 oldest. An add item goes straight to the result register:
// with the ring full the whole row shifts toward cell 0, the oldest handle
// comes out as evicted and the new entry lands in the last cell. A find item
// sends a token down the row, one cell per cycle while the row is not held,
// each cell subtracting its size from the remaining offset. The token passes
// through the register of every cell in the row and then into the result
// register, so the length of a find is set by the length of the cell row. One
// item is in flight at a time; the result register lets the next item in as
// soon as the current result is taken or in the same cycle. Slots read back as
// ring positions counted from the read index, as in a plain ring buffer.
module ring_entry_store_offset_lookup_core
    import reso_pkg::*;
#(
    parameter int RING_SLOTS = RING_SLOTS_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // [31:0] entry_handle, [47:32] entry_size, [67:48] lookup_offset, rest zero
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // [0] mode
    input  wire logic                   s_axis_tuser,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // [0] evicted, [32:1] evicted_handle, [33] found, [65:34] found_handle,
    // [69:66] found_slot, [85:70] byte_offset, rest zero
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata
);

    localparam int SLOT_W = $clog2(RING_SLOTS);
    localparam int CNT_W  = $clog2(RING_SLOTS + 1);

    t_state r_state, n_state;

    logic [SLOT_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_out_valid, n_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data, n_out_data;

    logic   in_acc;
    logic   add_go;
    logic   full;
    logic   chain_en;
    t_entry in_entry;
    t_tok   tok [0:RING_SLOTS];
    t_entry entries [0:RING_SLOTS-1];
    t_tok   last;

    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign add_go   = in_acc && (s_axis_tuser == MODE_ADD);
    assign full     = (r_cnt == CNT_W'(RING_SLOTS));
    assign in_entry = '{handle: s_axis_tdata[31:0], size: s_axis_tdata[47:32]};
    assign last     = tok[RING_SLOTS];

    // Hold the row while a finished lookup cannot move into the output register.
    assign chain_en = !(last.valid && r_out_valid && !m_axis_tready);

    always_comb begin
        tok[0]        = '0;
        tok[0].valid  = in_acc && (s_axis_tuser == MODE_FIND);
        tok[0].rem    = s_axis_tdata[67:48];
    end

    for (genvar k = 0; k < RING_SLOTS; k++) begin : g_cell
        logic [SLOT_W:0]   slot_sum;
        logic [SLOT_W-1:0] slot;
        logic              ld;
        t_entry            ld_entry;

        assign slot_sum = {1'b0, r_rd} + (SLOT_W+1)'(k);
        assign slot     = (slot_sum >= (SLOT_W+1)'(RING_SLOTS))
                        ? SLOT_W'(slot_sum - (SLOT_W+1)'(RING_SLOTS))
                        : SLOT_W'(slot_sum);
        assign ld       = add_go && (full || (r_cnt == CNT_W'(k)));

        if (k < RING_SLOTS - 1) begin : g_mid
            assign ld_entry = full ? entries[k+1] : in_entry;
        end else begin : g_end
            assign ld_entry = in_entry;
        end

        reso_cell #(
            .SLOT_W (SLOT_W)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_en       (chain_en),
            .i_live     (r_cnt > CNT_W'(k)),
            .i_slot     (slot),
            .i_ld       (ld),
            .i_ld_entry (ld_entry),
            .o_entry    (entries[k]),
            .i_tok      (tok[k]),
            .o_tok      (tok[k+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_rd        <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rd        <= n_rd;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
    end

    always_comb begin
        n_state     = r_state;
        n_rd        = r_rd;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;

        s_axis_tready = (r_state == ST_IDLE) && (!r_out_valid || m_axis_tready);

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (s_axis_tuser == MODE_ADD) begin
                        n_out_valid = 1'b1;
                        n_out_data  = '0;
                        if (full) begin
                            n_out_data[0]    = 1'b1;
                            n_out_data[32:1] = entries[0].handle;
                            n_rd = (r_rd == SLOT_W'(RING_SLOTS - 1)) ? '0 : r_rd + 1'b1;
                        end else begin
                            n_cnt = r_cnt + 1'b1;
                        end
                    end else begin
                        n_state = ST_WALK;
                    end
                end
            end
            ST_WALK: begin
                if (last.valid && chain_en) begin
                    n_out_valid = 1'b1;
                    n_out_data  = '0;
                    if (last.found) begin
                        n_out_data[33]    = 1'b1;
                        n_out_data[65:34] = last.handle;
                        n_out_data[69:66] = last.slot;
                        n_out_data[85:70] = last.rem[15:0];
                    end
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

`default_nettype wire

FILE: rtl/core/reso_cell.sv
`default_nettype none

module reso_cell
    import reso_pkg::*;
#(
    parameter int SLOT_W = 4
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_live,
    input  wire logic [SLOT_W-1:0] i_slot,
    input  wire logic              i_ld,
    input  wire t_entry            i_ld_entry,
    output t_entry                 o_entry,
    input  wire t_tok              i_tok,
    output t_tok                   o_tok
);

    t_entry r_entry;
    t_tok   r_tok;
    t_tok   n_tok;

    always_ff @(posedge i_clk) begin
        if (i_ld) begin
            r_entry <= i_ld_entry;
        end
    end

    always_comb begin
        n_tok = i_tok;
        if (i_tok.valid && !i_tok.found && i_live) begin
            if (i_tok.rem < OFFSET_W'(r_entry.size)) begin
                n_tok.found  = 1'b1;
                n_tok.handle = r_entry.handle;
                n_tok.slot   = SLOT_OUT_W'(i_slot);
            end else begin
                n_tok.rem = i_tok.rem - OFFSET_W'(r_entry.size);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else if (i_en) begin
            r_tok <= n_tok;
        end
    end

    assign o_entry = r_entry;
    assign o_tok   = r_tok;

endmodule

`default_nettype wire
